// ===== hdl/sstf_pkg.sv =====
// Shared types, constants and helpers of the SSTF disk scheduler.
`timescale 1ns / 1ps
package sstf_pkg;

   localparam int MaxRequests = 16;
   localparam int Cylinders   = 5000;
   localparam int SlotWidth   = $clog2(MaxRequests);
   localparam int CountWidth  = $clog2(MaxRequests + 1);
   localparam int CylWidth    = 13;
   localparam int SumWidth    = 17;
   localparam int CmdDepth    = 4;
   localparam int CmdPtrWidth = $clog2(CmdDepth);
   localparam int CmdCntWidth = $clog2(CmdDepth + 1);

   localparam logic [CylWidth-1:0]   CylMax   = CylWidth'(Cylinders - 1);
   localparam logic [SumWidth-1:0]   SumMax   = '1;
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MaxRequests);

   typedef struct packed {
      logic [CylWidth-1:0] cylinder;
      logic                last_request;
   } req_type;

   typedef struct packed {
      logic [CylWidth-1:0]  served_cylinder;
      logic [SlotWidth-1:0] request_index;
      logic [CylWidth-1:0]  seek_distance;
      logic [SumWidth-1:0]  total_movement;
      logic                 overflow;
      logic                 last_result;
   } rsp_type;

   // One classified request handed from the front end to the scheduler.
   typedef struct packed {
      logic [CylWidth-1:0]  cylinder;
      logic [SlotWidth-1:0] slot;
      logic                 keep;
      logic                 last;
      logic                 overflow;
   } cmd_type;

   function automatic logic [CylWidth-1:0] clamp_cyl(input logic [CylWidth-1:0] value);
      logic [CylWidth-1:0] result;
      result = (value > CylMax) ? CylMax : value;
      return result;
   endfunction

endpackage

// ===== hdl/sstf_front.sv =====
// Front end: clamps each request, assigns its slot and flags batch overflow.
`timescale 1ns / 1ps
module sstf_front
   import sstf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_push,
   output cmd_type cmd_data,
   input  logic    cmd_full
);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  drop_ff, drop_in;
   logic                  keep;

   assign req_full = cmd_full;
   assign cmd_push = req_push & ~cmd_full;
   assign keep     = (count_ff != CountMax);

   always_comb begin
      cmd_data.cylinder = clamp_cyl(req_data.cylinder);
      cmd_data.slot     = count_ff[SlotWidth-1:0];
      cmd_data.keep     = keep;
      cmd_data.last     = req_data.last_request;
      cmd_data.overflow = drop_ff | ~keep;
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (cmd_push) begin
         if (req_data.last_request) begin
            // batch closes here: start counting afresh
            count_in = '0;
            drop_in  = 1'b0;
         end else begin
            count_in = count_ff + CountWidth'(keep);
            drop_in  = drop_ff | ~keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// ===== hdl/sstf_cmd_queue.sv =====
// Short queue of classified requests between the front end and the scheduler.
`timescale 1ns / 1ps
module sstf_cmd_queue
   import sstf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type                mem_ff [CmdDepth];
   logic [CmdPtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CmdCntWidth-1:0] count_ff;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CmdCntWidth'(CmdDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CmdCntWidth'(do_push) - CmdCntWidth'(do_pop);
      end
   end

endmodule

// ===== hdl/sstf_back.sv =====
// Scheduler: stores the batch, scans for the nearest request and queues results.
`timescale 1ns / 1ps
module sstf_back
   import sstf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CylWidth-1:0] start_cylinder,
   input  cmd_type             cmd_data,
   input  logic                cmd_empty,
   output logic                cmd_pop,
   output rsp_type             rsp_data,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [CylWidth-1:0]   store_ff [MaxRequests];
   logic [MaxRequests-1:0] served_ff;
   logic [CountWidth-1:0] cnt_ff;
   logic [SlotWidth-1:0]  scan_ff, step_ff, best_ff;
   logic [CylWidth-1:0]   head_ff, best_cyl_ff, best_dist_ff;
   logic [SumWidth-1:0]   sum_ff;
   logic                  found_ff, ovf_ff;

   rsp_type               oq_ff [2];
   logic                  oq_wr_ff, oq_rd_ff;
   logic [1:0]            oq_cnt_ff;

   logic [CylWidth-1:0]   cur_cyl, cur_seek;
   logic [SumWidth:0]     sum_wide;
   logic [SumWidth-1:0]   sum_sat;
   logic                  take, scan_done, batch_done, oq_full, emit_fire, oq_pop;
   rsp_type               result;

   assign cur_cyl    = store_ff[scan_ff];
   assign cur_seek   = (cur_cyl >= head_ff) ? (cur_cyl - head_ff) : (head_ff - cur_cyl);
   // strict compare keeps the lowest index on a tie
   assign take       = ~served_ff[scan_ff] & (~found_ff | (cur_seek < best_dist_ff));
   assign scan_done  = ({1'b0, scan_ff} == cnt_ff - 1'b1);
   assign batch_done = ({1'b0, step_ff} == cnt_ff - 1'b1);
   assign sum_wide   = {1'b0, sum_ff} + (SumWidth + 1)'(best_dist_ff);
   assign sum_sat    = sum_wide[SumWidth] ? SumMax : sum_wide[SumWidth-1:0];

   assign oq_full    = (oq_cnt_ff == 2'd2);
   assign rsp_empty  = (oq_cnt_ff == 2'd0);
   assign oq_pop     = rsp_pop & ~rsp_empty;
   assign emit_fire  = (state_ff == ST_EMIT) & ~oq_full;
   assign cmd_pop    = (state_ff == ST_LOAD) & ~cmd_empty;
   assign rsp_data   = oq_ff[oq_rd_ff];

   always_comb begin
      result.served_cylinder = best_cyl_ff;
      result.request_index   = best_ff;
      result.seek_distance   = best_dist_ff;
      result.total_movement  = sum_sat;
      result.overflow        = ovf_ff;
      result.last_result     = batch_done;
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_data.keep) begin
         store_ff[cmd_data.slot] <= cmd_data.cylinder;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         oq_ff[oq_wr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         if (emit_fire) begin
            oq_wr_ff <= ~oq_wr_ff;
         end
         if (oq_pop) begin
            oq_rd_ff <= ~oq_rd_ff;
         end
         oq_cnt_ff <= oq_cnt_ff + 2'(emit_fire) - 2'(oq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         served_ff    <= '0;
         cnt_ff       <= '0;
         scan_ff      <= '0;
         step_ff      <= '0;
         best_ff      <= '0;
         head_ff      <= '0;
         best_cyl_ff  <= '0;
         best_dist_ff <= '0;
         sum_ff       <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (cmd_pop && cmd_data.last) begin
                  cnt_ff    <= cmd_data.keep ? ({1'b0, cmd_data.slot} + 1'b1) : CountMax;
                  ovf_ff    <= cmd_data.overflow;
                  head_ff   <= clamp_cyl(start_cylinder);
                  sum_ff    <= '0;
                  served_ff <= '0;
                  step_ff   <= '0;
                  scan_ff   <= '0;
                  found_ff  <= 1'b0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (take) begin
                  found_ff     <= 1'b1;
                  best_ff      <= scan_ff;
                  best_cyl_ff  <= cur_cyl;
                  best_dist_ff <= cur_seek;
               end
               scan_ff <= scan_ff + 1'b1;
               if (scan_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  head_ff            <= best_cyl_ff;
                  sum_ff             <= sum_sat;
                  scan_ff            <= '0;
                  found_ff           <= 1'b0;
                  step_ff            <= step_ff + 1'b1;
                  if (batch_done) begin
                     served_ff <= '0;
                     state_ff  <= ST_LOAD;
                  end else begin
                     served_ff[best_ff] <= 1'b1;
                     state_ff           <= ST_SCAN;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

endmodule

// ===== hdl/sstf_disk_scheduler_core.sv =====
// A request reaches the scheduler queue in the cycle after it is pushed.
// Requests of a batch load one per cycle while the scheduler is in its load state
// and the queue holds requests; after the last one, each of the n results is found
// by a scan of all n stored requests on the single store read port and an emit step.
// Reset is synchronous: queues empty, counters and flags clear, start cylinder 0;
// the request store holds no reset value and is read only where written.
`timescale 1ns / 1ps
module sstf_disk_scheduler_core
   import sstf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  req_type             req_data,
   output logic                req_full,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [CylWidth-1:0] csr_wr_data
);

   logic [CylWidth-1:0] start_cyl_ff;
   logic                fe_push, cq_full, cq_empty, cq_pop;
   cmd_type             fe_data, cq_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_cyl_ff <= '0;
      end else if (csr_wr_en) begin
         start_cyl_ff <= csr_wr_data;
      end
   end

   sstf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (fe_push),
      .cmd_data (fe_data),
      .cmd_full (cq_full)
   );

   sstf_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_data),
      .full      (cq_full),
      .pop       (cq_pop),
      .pop_data  (cq_data),
      .empty     (cq_empty)
   );

   sstf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .start_cylinder (start_cyl_ff),
      .cmd_data       (cq_data),
      .cmd_empty      (cq_empty),
      .cmd_pop        (cq_pop),
      .rsp_data       (rsp_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

`ifndef SYNTH
   a_served_in_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.served_cylinder <= CylMax))
      else $error("served cylinder beyond range");

   a_total_covers_seek: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.total_movement >= SumWidth'(rsp_data.seek_distance)))
      else $error("running total below step distance");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");
`endif

endmodule
